// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the safety checker.
// Defines nothing but property wrappers; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/bsc_pkg.sv =====
// Package of the safety checker: payload types, codes, sequencer types.
// No dependencies; used by bsc_seq and the top level.
`default_nettype none
package bsc_pkg;

  localparam int unsigned MaxProcessesDef = 8;
  localparam int unsigned MaxResourcesDef = 4;
  localparam int unsigned CountWidthDef   = 16;

  localparam int unsigned ProcIdWidth    = 3;
  localparam int unsigned ResIdWidth     = 2;
  localparam int unsigned ValueWidth     = 16;
  localparam int unsigned ProcCountWidth = 4;
  localparam int unsigned ResCountWidth  = 3;
  localparam int unsigned CfgDataWidth   = 4;

  localparam logic [ProcCountWidth-1:0] ProcCountReset = 4'd8;
  localparam logic [ResCountWidth-1:0]  ResCountReset  = 3'd4;

  typedef enum logic [1:0] {
    KIND_CLAIM = 2'd0,
    KIND_HELD  = 2'd1,
    KIND_AVAIL = 2'd2,
    KIND_RUN   = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_PROCESS_COUNT  = 1'b0,
    CFG_RESOURCE_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e                 kind;
    logic [ProcIdWidth-1:0] process;
    logic [ResIdWidth-1:0]  resource;
    logic [ValueWidth-1:0]  value;
  } bsc_in_t;

  typedef struct packed {
    logic                   entry_valid;
    logic [ProcIdWidth-1:0] process_id;
    logic                   safe;
    logic                   last;
  } bsc_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'd0,
    ST_IDLE   = 4'd1,
    ST_SCAN   = 4'd2,
    ST_FIT_RD = 4'd3,
    ST_FIT_EV = 4'd4,
    ST_REL_RD = 4'd5,
    ST_REL_EV = 4'd6,
    ST_NEXT   = 4'd7,
    ST_EMIT   = 4'd8
  } seq_state_e;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic idle;
    logic run_init;
    logic release_wr;
    logic mark_done;
    logic emit;
    logic emit_safe;
    logic emit_last;
  } seq_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic run_go;
    logic fits;
    logic p_finished;
    logic out_take;
  } seq_stat_t;

endpackage
`default_nettype wire

// ===== design/bsc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bsc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] addr_i,
  input  wire logic [Width-1:0]     wdata_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/bsc_alu.sv =====
// Shared add / compare / saturate unit of the safety checker.
// No dependencies.
`default_nettype none
module bsc_alu #(
  parameter int unsigned CountWidth = 16,
  parameter int unsigned WorkWidth  = 19
) (
  input  wire logic [WorkWidth-1:0]  work_i,
  input  wire logic [CountWidth-1:0] held_i,
  input  wire logic [CountWidth-1:0] claim_i,
  output logic      [WorkWidth-1:0]  sum_o,
  output logic                       fits_o
);

  logic [WorkWidth:0] sum_full;

  // held + work >= claim is the same as claim - held <= work, with no borrow.
  assign sum_full = {1'b0, work_i} + (WorkWidth + 1)'(held_i);
  assign fits_o   = sum_full >= (WorkWidth + 1)'(claim_i);
  assign sum_o    = sum_full[WorkWidth] ? '1 : sum_full[WorkWidth-1:0];

endmodule
`default_nettype wire

// ===== design/bsc_seq.sv =====
// Sequencer of the safety checker: table clearing, scan passes, result emission.
// Depends on bsc_pkg.
`default_nettype none
module bsc_seq import bsc_pkg::*; #(
  parameter int unsigned MaxProcesses = MaxProcessesDef,
  parameter int unsigned MaxResources = MaxResourcesDef,
  localparam int unsigned Depth     = MaxProcesses * MaxResources,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned PIdxW     = (MaxProcesses > 1) ? $clog2(MaxProcesses) : 1,
  localparam int unsigned RIdxW     = (MaxResources > 1) ? $clog2(MaxResources) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ProcCountWidth-1:0] process_count_i,
  input  wire logic [ResCountWidth-1:0]  resource_count_i,
  input  wire seq_stat_t                 stat_i,
  output seq_ctrl_t                      ctrl_o,
  output logic      [PIdxW-1:0]          p_o,
  output logic      [RIdxW-1:0]          r_o,
  output logic      [PIdxW-1:0]          total_idx_o,
  output logic      [PIdxW-1:0]          emit_idx_o,
  output logic      [AddrWidth-1:0]      clr_addr_o
);

  localparam int unsigned NW = $clog2(MaxProcesses + 1);
  localparam int unsigned MW = $clog2(MaxResources + 1);

  seq_state_e           state_q, state_d;
  logic [PIdxW-1:0]     p_q, p_d;
  logic [RIdxW-1:0]     r_q, r_d;
  logic [NW-1:0]        n_q, n_d;
  logic [MW-1:0]        m_q, m_d;
  logic [NW-1:0]        total_q, total_d;
  logic                 progress_q, progress_d;
  logic                 unsafe_q, unsafe_d;
  logic [PIdxW-1:0]     emit_q, emit_d;
  logic [AddrWidth-1:0] clr_q, clr_d;

  logic [NW-1:0] n_run;
  logic [MW-1:0] m_run;
  logic          r_last, p_last, emit_last, clr_last, all_done;

  // Clamp the configured counts into 1..MAX.
  always_comb begin
    if (process_count_i == '0) begin
      n_run = NW'(1);
    end else if (int'(process_count_i) > int'(MaxProcesses)) begin
      n_run = NW'(MaxProcesses);
    end else begin
      n_run = NW'(process_count_i);
    end
    if (resource_count_i == '0) begin
      m_run = MW'(1);
    end else if (int'(resource_count_i) > int'(MaxResources)) begin
      m_run = MW'(MaxResources);
    end else begin
      m_run = MW'(resource_count_i);
    end
  end

  assign r_last    = (MW'(r_q) + MW'(1)) == m_q;
  assign p_last    = (NW'(p_q) + NW'(1)) == n_q;
  assign emit_last = (NW'(emit_q) + NW'(1)) == n_q;
  assign clr_last  = clr_q == AddrWidth'(Depth - 1);
  assign all_done  = total_q == n_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (stat_i.run_go) state_d = ST_SCAN;
      ST_SCAN:   state_d = stat_i.p_finished ? ST_NEXT : ST_FIT_RD;
      ST_FIT_RD: state_d = ST_FIT_EV;
      ST_FIT_EV: begin
        if (!stat_i.fits) begin
          state_d = ST_NEXT;
        end else if (r_last) begin
          state_d = ST_REL_RD;
        end else begin
          state_d = ST_FIT_RD;
        end
      end
      ST_REL_RD: state_d = ST_REL_EV;
      ST_REL_EV: state_d = r_last ? ST_NEXT : ST_REL_RD;
      ST_NEXT: begin
        if (!p_last) begin
          state_d = ST_SCAN;
        end else if (!all_done && progress_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_take && (unsafe_q || emit_last)) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Strobes.
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_CLEAR: ctrl_o.clear_wr = 1'b1;
      ST_IDLE: begin
        ctrl_o.idle     = 1'b1;
        ctrl_o.run_init = stat_i.run_go;
      end
      ST_REL_EV: begin
        ctrl_o.release_wr = 1'b1;
        ctrl_o.mark_done  = r_last;
      end
      ST_EMIT: begin
        ctrl_o.emit      = 1'b1;
        ctrl_o.emit_safe = !unsafe_q;
        ctrl_o.emit_last = unsafe_q || emit_last;
      end
      default: ctrl_o = '0;
    endcase
  end

  // Counters.
  always_comb begin
    p_d        = p_q;
    r_d        = r_q;
    n_d        = n_q;
    m_d        = m_q;
    total_d    = total_q;
    progress_d = progress_q;
    unsafe_d   = unsafe_q;
    emit_d     = emit_q;
    clr_d      = clr_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + AddrWidth'(1);
      ST_IDLE: begin
        if (stat_i.run_go) begin
          n_d        = n_run;
          m_d        = m_run;
          p_d        = '0;
          r_d        = '0;
          total_d    = '0;
          progress_d = 1'b0;
        end
      end
      ST_SCAN: r_d = '0;
      ST_FIT_EV: begin
        if (stat_i.fits) r_d = r_last ? '0 : r_q + RIdxW'(1);
      end
      ST_REL_EV: begin
        if (r_last) begin
          total_d    = total_q + NW'(1);
          progress_d = 1'b1;
        end else begin
          r_d = r_q + RIdxW'(1);
        end
      end
      ST_NEXT: begin
        if (!p_last) begin
          p_d = p_q + PIdxW'(1);
        end else if (all_done) begin
          unsafe_d = 1'b0;
          emit_d   = '0;
        end else if (progress_q) begin
          p_d        = '0;
          progress_d = 1'b0;
        end else begin
          unsafe_d = 1'b1;
          emit_d   = '0;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_take && !emit_last) emit_d = emit_q + PIdxW'(1);
      end
      default: clr_d = clr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      p_q        <= '0;
      r_q        <= '0;
      n_q        <= '0;
      m_q        <= '0;
      total_q    <= '0;
      progress_q <= 1'b0;
      unsafe_q   <= 1'b0;
      emit_q     <= '0;
      clr_q      <= '0;
    end else begin
      state_q    <= state_d;
      p_q        <= p_d;
      r_q        <= r_d;
      n_q        <= n_d;
      m_q        <= m_d;
      total_q    <= total_d;
      progress_q <= progress_d;
      unsafe_q   <= unsafe_d;
      emit_q     <= emit_d;
      clr_q      <= clr_d;
    end
  end

  assign p_o         = p_q;
  assign r_o         = r_q;
  assign total_idx_o = total_q[PIdxW-1:0];
  assign emit_idx_o  = emit_q;
  assign clr_addr_o  = clr_q;

endmodule
`default_nettype wire

// ===== design/banker_safety_check_top.sv =====
// Top level of the Banker's safety checker: config registers, vectors, tables.
// Depends on bsc_pkg, bsc_ram, bsc_alu, bsc_seq and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Banker's safety check. Load words (kind claim, held or available) write one
// entry of the claim table, the held table or the available vector; they give
// no result. A run word copies available into work and scans the unfinished
// processes in index order, pass after pass: a process whose need fits work in
// every resource in use releases its holding into work and joins the safe
// order. The run then returns the order, one word per process with last on the
// final one, or one unsafe word (entry_valid 0, safe 0, last 1). The block
// stalls input from the run word until its last result is taken. All count
// arithmetic goes through one shared add/compare unit and the tables are
// single-port RAMs with registered read, so each resource is checked and
// released in a read state and an evaluate state. A finished process goes from
// SCAN straight to NEXT; a failing visit stops at the first resource that does
// not fit. There are at most n passes over the n processes in use, then n
// result words (or one). After reset the tables are zeroed by a clearing sweep
// over all MAX_PROCESSES * MAX_RESOURCES entries (32 by default), during which
// input is stalled; configuration writes are always taken.
module banker_safety_check_top import bsc_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MaxProcessesDef,
  parameter int unsigned MAX_RESOURCES = MaxResourcesDef,
  parameter int unsigned COUNT_WIDTH   = CountWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire bsc_in_t                 in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output bsc_out_t                     out_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [0:0]              cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned Depth     = MAX_PROCESSES * MAX_RESOURCES;
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PIdxW     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned RIdxW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  // Room for MAX_PROCESSES full counts; larger sums saturate.
  localparam int unsigned WorkWidth = COUNT_WIDTH + $clog2(MAX_PROCESSES);

  seq_ctrl_t ctrl;
  seq_stat_t stat;

  logic [ProcCountWidth-1:0] process_count_q;
  logic [ResCountWidth-1:0]  resource_count_q;
  logic [COUNT_WIDTH-1:0]    avail_q    [MAX_RESOURCES];
  logic [WorkWidth-1:0]      work_q     [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0]  finished_q;
  logic [ProcIdWidth-1:0]    order_q    [MAX_PROCESSES];

  logic [PIdxW-1:0]       p_idx, total_idx, emit_idx;
  logic [RIdxW-1:0]       r_idx;
  logic [AddrWidth-1:0]   clr_addr, load_addr, scan_addr, ram_addr;
  logic [COUNT_WIDTH-1:0] ram_wdata, claim_rd, held_rd;
  logic [WorkWidth-1:0]   alu_sum;
  logic                   alu_fits;

  logic in_take, load_take, proc_ok, res_ok;
  logic claim_we, held_we, avail_we;
  logic cfg_take;

  // Input side: take words only in idle.
  assign in_stall_o = !ctrl.idle;
  assign in_take    = in_valid_i && ctrl.idle;
  assign load_take  = in_take && (in_i.kind != KIND_RUN);
  // Drop writes that land beyond the table sizes.
  assign proc_ok    = int'(in_i.process) < int'(MAX_PROCESSES);
  assign res_ok     = int'(in_i.resource) < int'(MAX_RESOURCES);

  assign claim_we = ctrl.clear_wr || (load_take && in_i.kind == KIND_CLAIM && proc_ok && res_ok);
  assign held_we  = ctrl.clear_wr || (load_take && in_i.kind == KIND_HELD && proc_ok && res_ok);
  assign avail_we = load_take && in_i.kind == KIND_AVAIL && res_ok;

  assign load_addr = AddrWidth'(int'(in_i.process) * int'(MAX_RESOURCES) + int'(in_i.resource));
  assign scan_addr = AddrWidth'(int'(p_idx) * int'(MAX_RESOURCES) + int'(r_idx));

  always_comb begin
    if (ctrl.clear_wr) begin
      ram_addr = clr_addr;
    end else if (ctrl.idle) begin
      ram_addr = load_addr;
    end else begin
      ram_addr = scan_addr;
    end
  end

  assign ram_wdata = ctrl.clear_wr ? '0 : COUNT_WIDTH'(in_i.value);

  bsc_ram #(
    .Width (COUNT_WIDTH),
    .Depth (Depth)
  ) u_claim_ram (
    .clk_i   (clk_i),
    .we_i    (claim_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (claim_rd)
  );

  bsc_ram #(
    .Width (COUNT_WIDTH),
    .Depth (Depth)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (held_rd)
  );

  // One adder serves both the fit test and the release into work.
  bsc_alu #(
    .CountWidth (COUNT_WIDTH),
    .WorkWidth  (WorkWidth)
  ) u_alu (
    .work_i  (work_q[r_idx]),
    .held_i  (held_rd),
    .claim_i (claim_rd),
    .sum_o   (alu_sum),
    .fits_o  (alu_fits)
  );

  assign stat.run_go     = in_take && (in_i.kind == KIND_RUN);
  assign stat.fits       = alu_fits;
  assign stat.p_finished = finished_q[p_idx];
  assign stat.out_take   = out_valid_o && !out_stall_i;

  bsc_seq #(
    .MaxProcesses (MAX_PROCESSES),
    .MaxResources (MAX_RESOURCES)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .process_count_i  (process_count_q),
    .resource_count_i (resource_count_q),
    .stat_i           (stat),
    .ctrl_o           (ctrl),
    .p_o              (p_idx),
    .r_o              (r_idx),
    .total_idx_o      (total_idx),
    .emit_idx_o       (emit_idx),
    .clr_addr_o       (clr_addr)
  );

  // Configuration registers; the port never back-pressures.
  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_count_q  <= ProcCountReset;
      resource_count_q <= ResCountReset;
    end else if (cfg_take) begin
      if (cfg_index_i == CFG_PROCESS_COUNT) begin
        process_count_q <= ProcCountWidth'(cfg_data_i);
      end
      if (cfg_index_i == CFG_RESOURCE_COUNT) begin
        resource_count_q <= ResCountWidth'(cfg_data_i);
      end
    end
  end

  // Available, work and finished flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(MAX_RESOURCES); k++) begin
        avail_q[k] <= '0;
        work_q[k]  <= '0;
      end
      finished_q <= '0;
    end else begin
      if (avail_we) begin
        avail_q[RIdxW'(in_i.resource)] <= COUNT_WIDTH'(in_i.value);
      end
      if (ctrl.run_init) begin
        // Start work as a copy of available and forget the previous run.
        for (int k = 0; k < int'(MAX_RESOURCES); k++) begin
          work_q[k] <= WorkWidth'(avail_q[k]);
        end
        finished_q <= '0;
      end
      if (ctrl.release_wr) begin
        work_q[r_idx] <= alu_sum;
      end
      if (ctrl.mark_done) begin
        finished_q[p_idx] <= 1'b1;
      end
    end
  end

  // Safe order; entries are read only after this run wrote them.
  always_ff @(posedge clk_i) begin
    if (ctrl.mark_done) begin
      order_q[total_idx] <= ProcIdWidth'(p_idx);
    end
  end

  // Result word, held steady by the sequencer while stalled.
  assign out_valid_o       = ctrl.emit;
  assign out_o.entry_valid = ctrl.emit_safe;
  assign out_o.process_id  = ctrl.emit_safe ? order_q[emit_idx] : '0;
  assign out_o.safe        = ctrl.emit_safe;
  assign out_o.last        = ctrl.emit_last;

  `ASSERT_IMP(a_idle_no_result, clk_i, rst_ni, !in_stall_o, !out_valid_o)
  `ASSERT_IMP(a_unsafe_is_last, clk_i, rst_ni, out_valid_o && !out_o.safe, out_o.last && !out_o.entry_valid)
  `ASSERT_NXT(a_last_frees_input, clk_i, rst_ni, out_valid_o && !out_stall_i && out_o.last, !in_stall_o)
  `ASSERT_NXT(a_run_stalls_input, clk_i, rst_ni, in_valid_i && !in_stall_o && in_i.kind == KIND_RUN, in_stall_o)

endmodule
`default_nettype wire
